### src/ascii_radix_integer_parser_defines.svh
// Assertion macros used by the file that checks its own logic.
`ifndef ASCII_RADIX_INTEGER_PARSER_DEFINES_SVH
`define ASCII_RADIX_INTEGER_PARSER_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define ARIP_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Consequence must hold in the cycle after the antecedent.
`define ARIP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### src/arip_pkg.sv
`default_nettype none

package arip_pkg;

	localparam int CHAR_W          = 8;
	localparam int RADIX_W         = 6;
	localparam int VALUE_W         = 64;
	localparam int END_W           = 12;
	localparam int MAC_W           = VALUE_W + RADIX_W;
	localparam int MAX_STRING_LEN  = 4096;

	localparam logic [RADIX_W-1:0] RADIX_OCT = RADIX_W'(8);
	localparam logic [RADIX_W-1:0] RADIX_DEC = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] RADIX_HEX = RADIX_W'(16);

	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
	localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
	localparam logic [CHAR_W-1:0] NOT_DIGIT  = 8'hFF;

	typedef enum logic [2:0] {
		PH_SKIP   = 3'd0,
		PH_PREFIX = 3'd1,
		PH_ZERO   = 3'd2,
		PH_DIGITS = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	typedef struct packed {
		logic step;
		logic clear;
		logic finish;
		logic base8;
		logic end_inc;
		logic end_at_pos;
		logic sign_load;
		logic acc_load;
		logic ovf_set;
		logic radix_fill;
		logic radix_16;
	} cmd_t;

	typedef struct packed {
		logic is_space;
		logic is_sign;
		logic is_zero;
		logic is_x;
		logic radix_auto;
		logic radix_16;
		logic digit_ok;
		logic mul_ovf;
	} sts_t;

	function automatic logic [CHAR_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] d;
		d = NOT_DIGIT;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = c - CH_ZERO;
		end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			d = c - CH_UPPER_A + CHAR_W'(10);
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			d = c - CH_LOWER_A + CHAR_W'(10);
		end
		return d;
	endfunction

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

endpackage

`default_nettype wire

### src/arip_dp.sv
`default_nettype none

module arip_dp #(
	parameter int MAX_STRING_LEN = arip_pkg::MAX_STRING_LEN
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [arip_pkg::CHAR_W-1:0]    character,
	input  wire logic [arip_pkg::RADIX_W-1:0]   radix,
	input  wire arip_pkg::cmd_t                 cmd,
	output arip_pkg::sts_t                      sts,
	output logic      [arip_pkg::VALUE_W-1:0]   value,
	output logic      [arip_pkg::END_W-1:0]     end_offset,
	output logic                                overflowed
);

	localparam int POS_W = $clog2(MAX_STRING_LEN);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_STRING_LEN - 1);

	logic [arip_pkg::VALUE_W-1:0] acc_q, acc_e, acc_n;
	logic [arip_pkg::RADIX_W-1:0] radix_q, radix_e, radix_n, base;
	logic [POS_W-1:0]             pos_q, pos_e, pos_n;
	logic [POS_W-1:0]             end_q, end_e, end_n;
	logic                         neg_q, neg_e, neg_n;
	logic                         ovf_q, ovf_e, ovf_n;
	logic                         in_range;
	logic [arip_pkg::CHAR_W-1:0]  chr, dig;
	logic [arip_pkg::MAC_W-1:0]   mac;

	logic [arip_pkg::VALUE_W-1:0]     out_acc_q;
	logic [POS_W-1:0]                 out_end_q;
	logic                             out_neg_q;
	logic                             out_ovf_q;
	logic [POS_W+arip_pkg::END_W-1:0] end_ext;

	always_comb begin
		// A first character starts from the cleared state, whatever is held.
		acc_e   = cmd.clear ? '0 : acc_q;
		radix_e = cmd.clear ? radix : radix_q;
		pos_e   = cmd.clear ? '0 : pos_q;
		end_e   = cmd.clear ? '0 : end_q;
		neg_e   = cmd.clear ? 1'b0 : neg_q;
		ovf_e   = cmd.clear ? 1'b0 : ovf_q;

		in_range = pos_e < LAST_POS;
		chr      = in_range ? character : '0;
		dig      = arip_pkg::digit_value(chr);

		if (radix_e == '0) begin
			base = cmd.base8 ? arip_pkg::RADIX_OCT : arip_pkg::RADIX_DEC;
		end else begin
			base = radix_e;
		end

		// Any carry above bit 63 means the accumulation would overflow.
		mac = ({{arip_pkg::RADIX_W{1'b0}}, acc_e} * {{arip_pkg::VALUE_W{1'b0}}, base})
			+ {{(arip_pkg::MAC_W - arip_pkg::CHAR_W){1'b0}}, dig};

		sts.is_space   = arip_pkg::is_space(chr);
		sts.is_sign    = (chr == arip_pkg::CH_PLUS) || (chr == arip_pkg::CH_MINUS);
		sts.is_zero    = chr == arip_pkg::CH_ZERO;
		sts.is_x       = (chr == arip_pkg::CH_LOWER_X) || (chr == arip_pkg::CH_UPPER_X);
		sts.radix_auto = radix_e == '0;
		sts.radix_16   = radix_e == arip_pkg::RADIX_HEX;
		sts.digit_ok   = dig < {{(arip_pkg::CHAR_W - arip_pkg::RADIX_W){1'b0}}, base};
		sts.mul_ovf    = |mac[arip_pkg::MAC_W-1:arip_pkg::VALUE_W];

		acc_n = cmd.acc_load ? mac[arip_pkg::VALUE_W-1:0] : acc_e;
		if (cmd.radix_16) begin
			radix_n = arip_pkg::RADIX_HEX;
		end else if (cmd.radix_fill) begin
			radix_n = base;
		end else begin
			radix_n = radix_e;
		end
		if (cmd.end_inc) begin
			end_n = pos_e + POS_W'(1);
		end else if (cmd.end_at_pos) begin
			end_n = pos_e;
		end else begin
			end_n = end_e;
		end
		neg_n = cmd.sign_load ? (chr == arip_pkg::CH_MINUS) : neg_e;
		ovf_n = ovf_e | cmd.ovf_set;
		pos_n = in_range ? pos_e + POS_W'(1) : pos_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			radix_q <= '0;
			pos_q   <= '0;
			end_q   <= '0;
			neg_q   <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (cmd.step) begin
			if (cmd.finish) begin
				acc_q   <= '0;
				radix_q <= '0;
				pos_q   <= '0;
				end_q   <= '0;
				neg_q   <= 1'b0;
				ovf_q   <= 1'b0;
			end else begin
				acc_q   <= acc_n;
				radix_q <= radix_n;
				pos_q   <= pos_n;
				end_q   <= end_n;
				neg_q   <= neg_n;
				ovf_q   <= ovf_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_acc_q <= acc_n;
			out_end_q <= end_n;
			out_neg_q <= neg_n;
			out_ovf_q <= ovf_n;
		end
	end

	always_comb begin
		// A negative magnitude above 2^63 gives zero; 2^63 itself negates to itself.
		if (out_ovf_q) begin
			value = '1;
		end else if (out_neg_q) begin
			if (out_acc_q[arip_pkg::VALUE_W-1] && |out_acc_q[arip_pkg::VALUE_W-2:0]) begin
				value = '0;
			end else begin
				value = '0 - out_acc_q;
			end
		end else begin
			value = out_acc_q;
		end
		end_ext    = {{arip_pkg::END_W{1'b0}}, out_end_q};
		end_offset = end_ext[arip_pkg::END_W-1:0];
		overflowed = out_ovf_q;
	end

endmodule

`default_nettype wire

### src/arip_ctrl.sv
`default_nettype none

module arip_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic           first_char,
	input  wire logic           last_char,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire arip_pkg::sts_t sts,
	output arip_pkg::cmd_t      cmd
);

	arip_pkg::phase_t phase_q, phase_e, phase_n, phase_d;
	logic             out_valid_q;
	logic             prefix_path, digit_path;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= arip_pkg::PH_SKIP;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		in_ready   = !out_valid_q || out_ready;
		out_valid  = out_valid_q;
		cmd        = '0;
		cmd.step   = in_valid && in_ready;
		cmd.clear  = first_char;
		cmd.finish = cmd.step && last_char;

		phase_e     = first_char ? arip_pkg::PH_SKIP : phase_q;
		phase_n     = phase_e;
		prefix_path = 1'b0;
		digit_path  = 1'b0;
		cmd.base8   = phase_e == arip_pkg::PH_ZERO;

		unique case (phase_e)
			arip_pkg::PH_SKIP: begin
				if (sts.is_space) begin
					cmd.end_inc = 1'b1;
				end else if (sts.is_sign) begin
					cmd.sign_load = 1'b1;
					cmd.end_inc   = 1'b1;
					phase_n       = arip_pkg::PH_PREFIX;
				end else begin
					prefix_path = 1'b1;
				end
			end
			arip_pkg::PH_PREFIX: begin
				prefix_path = 1'b1;
			end
			arip_pkg::PH_ZERO: begin
				if (sts.is_x) begin
					cmd.radix_16 = 1'b1;
					cmd.end_inc  = 1'b1;
					phase_n      = arip_pkg::PH_DIGITS;
				end else begin
					cmd.radix_fill = sts.radix_auto;
					digit_path     = 1'b1;
				end
			end
			arip_pkg::PH_DIGITS: begin
				digit_path = 1'b1;
			end
			default: begin
				phase_n = arip_pkg::PH_DONE;
			end
		endcase

		// A leading zero with auto or hex radix may open a 0x prefix.
		if (prefix_path) begin
			if ((sts.radix_auto || sts.radix_16) && sts.is_zero) begin
				cmd.end_inc = 1'b1;
				phase_n     = arip_pkg::PH_ZERO;
			end else begin
				cmd.radix_fill = sts.radix_auto;
				digit_path     = 1'b1;
			end
		end

		if (digit_path) begin
			if (!sts.digit_ok) begin
				phase_n = arip_pkg::PH_DONE;
			end else if (sts.mul_ovf) begin
				cmd.ovf_set    = 1'b1;
				cmd.end_at_pos = 1'b1;
				phase_n        = arip_pkg::PH_DONE;
			end else begin
				cmd.acc_load = 1'b1;
				cmd.end_inc  = 1'b1;
				phase_n      = arip_pkg::PH_DIGITS;
			end
		end

		if (!cmd.step) begin
			phase_d = phase_q;
		end else if (cmd.finish) begin
			phase_d = arip_pkg::PH_SKIP;
		end else begin
			phase_d = phase_n;
		end
	end

endmodule

`default_nettype wire

### src/ascii_radix_integer_parser.sv
// Channel | Direction | Handshake          | Beat contents
// input   | in        | in_valid/in_ready  | character, radix, first_char, last_char
// result  | out       | out_valid/out_ready| value, end_offset, overflowed
//
// One input beat is taken per clock cycle while in_ready is high; the digit
// multiply-add and its overflow test complete in the cycle accepting the character.
// A beat with last_char loads the result register, which is shown on the next cycle.
// Input is taken while the result register is empty or being read in the same cycle,
// so a held result stalls the input only until out_ready rises.
// Reset clears the parse state and the result register's valid flag at once.
`default_nettype none
`include "ascii_radix_integer_parser_defines.svh"

module ascii_radix_integer_parser #(
	parameter int MAX_STRING_LEN = arip_pkg::MAX_STRING_LEN
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [arip_pkg::CHAR_W-1:0]  character,
	input  wire logic [arip_pkg::RADIX_W-1:0] radix,
	input  wire logic                         first_char,
	input  wire logic                         last_char,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [arip_pkg::VALUE_W-1:0] value,
	output logic      [arip_pkg::END_W-1:0]   end_offset,
	output logic                              overflowed
);

	arip_pkg::cmd_t cmd;
	arip_pkg::sts_t sts;

	arip_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.first_char (first_char),
		.last_char  (last_char),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	arip_dp #(
		.MAX_STRING_LEN (MAX_STRING_LEN)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.character  (character),
		.radix      (radix),
		.cmd        (cmd),
		.sts        (sts),
		.value      (value),
		.end_offset (end_offset),
		.overflowed (overflowed)
	);

	`ARIP_ASSERT_SAME(a_stall_blocks_input, out_valid && !out_ready, !in_ready)
	`ARIP_ASSERT_NEXT(a_last_gives_result, in_valid && in_ready && last_char, out_valid)
	`ARIP_ASSERT_SAME(a_overflow_saturates, out_valid && overflowed, value == '1)

endmodule

`default_nettype wire
